// ===== src/regression_error_metrics_unit_macros.svh =====
// Assertion macros for the regression error metrics unit.
// Used by the port checker; no other dependencies.
`ifndef REGRESSION_ERROR_METRICS_UNIT_MACROS_SVH
`define REGRESSION_ERROR_METRICS_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define REM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define REM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/rem_pkg.sv =====
// Shared widths, constants and types of the regression error metrics unit.
// No dependencies.
`default_nettype none

package rem_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 17;
    localparam int ABS_W    = 33;
    localparam int SQ_W     = 48;
    localparam int LSUM_W   = 33;
    localparam int LSQ_W    = 47;
    localparam int MAE_W    = 16;
    localparam int MSE_W    = 32;
    localparam int RMSE_W   = 16;
    localparam int R2_W     = 20;
    localparam int PROD_W   = 65;
    localparam int ALU_W    = 96;
    localparam int STEP_W   = 6;

    localparam logic [CNT_W-1:0] MAX_ITEMS = CNT_W'(65536);
    localparam logic [R2_W-1:0]  R2_ONE    = R2_W'(65536);
    localparam logic [R2_W-1:0]  R2_SAT_Q  = R2_W'(589824);
    localparam logic [MSE_W-1:0] SQRT_B0   = 32'h4000_0000;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic [CNT_W-1:0]  n;
        logic [CNT_W-1:0]  cnt;
        logic              ovf;
        logic [ABS_W-1:0]  abs_sum;
        logic [SQ_W-1:0]   sq_sum;
        logic [LSUM_W-1:0] lsum_mag;
        logic [LSQ_W-1:0]  lsq_sum;
    } snap_t;

    typedef struct packed {
        logic [MAE_W-1:0]  mae;
        logic [MSE_W-1:0]  mse;
        logic [RMSE_W-1:0] rmse;
        logic [R2_W-1:0]   r2;
        logic              undef;
        logic [CNT_W-1:0]  cnt;
        logic              ovf;
    } res_t;

endpackage

`default_nettype wire

// ===== src/rem_alu.sv =====
// Shared wide add/subtract unit; carry out doubles as a >= b on subtract.
// Depends on rem_pkg.
`default_nettype none

module rem_alu
    import rem_pkg::*;
(
    input  alu_op_t          op,
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output logic [ALU_W-1:0] res,
    output logic             carry
);

    logic [ALU_W:0] sum;

    always_comb
    begin
        unique case (op)
            ALU_ADD: sum = {1'b0, a} + {1'b0, b};
            ALU_SUB: sum = {1'b0, a} + {1'b0, ~b} + (ALU_W+1)'(1);
            default: sum = '0;
        endcase
    end

    assign res   = sum[ALU_W-1:0];
    assign carry = sum[ALU_W];

endmodule

`default_nettype wire

// ===== src/rem_accum.sv =====
// Per-pair accumulators: count, error sums and label sums.
// Depends on rem_pkg; feeds a snapshot to the sequencer.
`default_nettype none

module rem_accum
    import rem_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                last,
    input  logic [SAMPLE_W-1:0] prediction,
    input  logic [SAMPLE_W-1:0] label,
    output snap_t               snap
);

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ABS_W-1:0]    abs_reg, abs_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [LSUM_W-1:0]   lsum_reg, lsum_next;
    logic [LSQ_W-1:0]    lsq_reg, lsq_next;
    logic                ovf_reg, ovf_next;
    logic [SAMPLE_W:0]   pext, lext, diff, ad, al;
    logic [2*SAMPLE_W+1:0] ad_sq, al_sq;
    logic                full;

    always_comb
    begin
        pext  = {prediction[SAMPLE_W-1], prediction};
        lext  = {label[SAMPLE_W-1], label};
        diff  = pext - lext;
        ad    = diff[SAMPLE_W] ? (~diff + (SAMPLE_W+1)'(1)) : diff;
        al    = lext[SAMPLE_W] ? (~lext + (SAMPLE_W+1)'(1)) : lext;
        ad_sq = ad * ad;
        al_sq = al * al;
        full  = (cnt_reg == MAX_ITEMS);

        cnt_next  = cnt_reg;
        abs_next  = abs_reg;
        sq_next   = sq_reg;
        lsum_next = lsum_reg;
        lsq_next  = lsq_reg;
        ovf_next  = ovf_reg;
        if (take)
        begin
            if (!full)
            begin
                cnt_next  = cnt_reg + CNT_W'(1);
                abs_next  = abs_reg + ABS_W'(ad);
                sq_next   = sq_reg + SQ_W'(ad_sq);
                lsum_next = lsum_reg + {{(LSUM_W-SAMPLE_W-1){lext[SAMPLE_W]}}, lext};
                lsq_next  = lsq_reg + LSQ_W'(al_sq);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        snap.n        = (cnt_next == '0) ? CNT_W'(1) : cnt_next;
        snap.cnt      = cnt_next;
        snap.ovf      = ovf_next;
        snap.abs_sum  = abs_next;
        snap.sq_sum   = sq_next;
        snap.lsum_mag = lsum_next[LSUM_W-1] ? (~lsum_next + LSUM_W'(1)) : lsum_next;
        snap.lsq_sum  = lsq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            abs_reg  <= '0;
            sq_reg   <= '0;
            lsum_reg <= '0;
            lsq_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (take && last)
        begin
            cnt_reg  <= '0;
            abs_reg  <= '0;
            sq_reg   <= '0;
            lsum_reg <= '0;
            lsq_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (take)
        begin
            cnt_reg  <= cnt_next;
            abs_reg  <= abs_next;
            sq_reg   <= sq_next;
            lsum_reg <= lsum_next;
            lsq_reg  <= lsq_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/rem_seq.sv =====
// Result sequencer: divisions, square root, products and R2 quotient,
// all stepped through the shared rem_alu. Depends on rem_pkg, rem_alu.
`default_nettype none

module rem_seq
    import rem_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  snap_t snap,
    input  logic  out_free,
    output logic  busy,
    output logic  done,
    output res_t  res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAE,
        S_MSE,
        S_SQRT,
        S_MUL_A,
        S_MUL_B,
        S_DIFF,
        S_MUL_C,
        S_SATCHK,
        S_R2Q,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  n_reg, cnt_reg;
    logic              ovf_reg, undef_reg;
    logic [SQ_W-1:0]   x_reg, q_reg, sq_keep_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [LSUM_W-1:0] lsm_reg, mr_reg;
    logic [LSQ_W-1:0]  lsq_reg;
    logic [MAE_W-1:0]  mae_reg;
    logic [MSE_W-1:0]  mse_reg, sx_reg, sr_reg, sb_reg;
    logic [ALU_W-1:0]  mm_reg, acc_reg;
    logic [PROD_W-1:0] a_reg, d_reg;
    logic [R2_W-1:0]   r2q_reg, qc;

    alu_op_t          alu_op;
    logic [ALU_W-1:0] alu_a, alu_b, alu_res;
    logic             ge;
    logic [CNT_W:0]   trial;
    logic [SQ_W-1:0]  q_shift;

    rem_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .carry (ge)
    );

    always_comb
    begin
        trial   = {rem_reg, x_reg[step_reg]};
        q_shift = {q_reg[SQ_W-2:0], ge};
        alu_op  = ALU_SUB;
        alu_a   = '0;
        alu_b   = '0;
        unique case (state_reg)
            S_MAE, S_MSE:
            begin
                alu_a = ALU_W'(trial);
                alu_b = ALU_W'(n_reg);
            end
            S_SQRT:
            begin
                alu_a = ALU_W'(sx_reg);
                alu_b = ALU_W'(sr_reg | sb_reg);
            end
            S_MUL_A, S_MUL_B, S_MUL_C:
            begin
                alu_op = ALU_ADD;
                alu_a  = acc_reg;
                alu_b  = mr_reg[0] ? mm_reg : '0;
            end
            S_DIFF:
            begin
                alu_a = ALU_W'(a_reg);
                alu_b = acc_reg;
            end
            S_SATCHK, S_R2Q:
            begin
                alu_a = acc_reg;
                alu_b = mm_reg;
            end
            S_IDLE, S_DONE:
            begin
                alu_op = ALU_ADD;
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg       <= snap.n;
                        cnt_reg     <= snap.cnt;
                        ovf_reg     <= snap.ovf;
                        sq_keep_reg <= snap.sq_sum;
                        lsm_reg     <= snap.lsum_mag;
                        lsq_reg     <= snap.lsq_sum;
                        x_reg       <= SQ_W'(snap.abs_sum);
                        rem_reg     <= '0;
                        q_reg       <= '0;
                        step_reg    <= STEP_W'(ABS_W - 1);
                        state_reg   <= S_MAE;
                    end
                end
                S_MAE, S_MSE:
                begin
                    if (step_reg == '0)
                    begin
                        rem_reg <= '0;
                        q_reg   <= '0;
                        if (state_reg == S_MAE)
                        begin
                            mae_reg   <= q_shift[MAE_W-1:0];
                            x_reg     <= sq_keep_reg;
                            step_reg  <= STEP_W'(SQ_W - 1);
                            state_reg <= S_MSE;
                        end
                        else
                        begin
                            mse_reg   <= q_shift[MSE_W-1:0];
                            sx_reg    <= q_shift[MSE_W-1:0];
                            sr_reg    <= '0;
                            sb_reg    <= SQRT_B0;
                            step_reg  <= STEP_W'(RMSE_W - 1);
                            state_reg <= S_SQRT;
                        end
                    end
                    else
                    begin
                        rem_reg  <= ge ? alu_res[CNT_W-1:0] : trial[CNT_W-1:0];
                        q_reg    <= q_shift;
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end
                S_SQRT:
                begin
                    if (ge)
                    begin
                        sx_reg <= alu_res[MSE_W-1:0];
                        sr_reg <= (sr_reg >> 1) | sb_reg;
                    end
                    else
                    begin
                        sr_reg <= sr_reg >> 1;
                    end
                    sb_reg <= sb_reg >> 2;
                    if (step_reg == '0)
                    begin
                        acc_reg   <= '0;
                        mr_reg    <= LSUM_W'(n_reg);
                        mm_reg    <= ALU_W'(lsq_reg);
                        step_reg  <= STEP_W'(CNT_W - 1);
                        state_reg <= S_MUL_A;
                    end
                    else
                    begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end
                S_MUL_A, S_MUL_B, S_MUL_C:
                begin
                    if (step_reg == '0)
                    begin
                        priority case (state_reg)
                            S_MUL_A:
                            begin
                                a_reg     <= alu_res[PROD_W-1:0];
                                acc_reg   <= '0;
                                mr_reg    <= lsm_reg;
                                mm_reg    <= ALU_W'(lsm_reg);
                                step_reg  <= STEP_W'(LSUM_W - 1);
                                state_reg <= S_MUL_B;
                            end
                            S_MUL_B:
                            begin
                                acc_reg   <= alu_res;
                                state_reg <= S_DIFF;
                            end
                            default:
                            begin
                                acc_reg   <= alu_res << 16;
                                mm_reg    <= ALU_W'(d_reg) << R2_W;
                                state_reg <= S_SATCHK;
                            end
                        endcase
                    end
                    else
                    begin
                        acc_reg  <= alu_res;
                        mr_reg   <= mr_reg >> 1;
                        mm_reg   <= mm_reg << 1;
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end
                S_DIFF:
                begin
                    d_reg <= alu_res[PROD_W-1:0];
                    if (!ge || alu_res == '0)
                    begin
                        undef_reg <= 1'b1;
                        r2q_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        undef_reg <= 1'b0;
                        acc_reg   <= '0;
                        mr_reg    <= LSUM_W'(n_reg);
                        mm_reg    <= ALU_W'(sq_keep_reg);
                        step_reg  <= STEP_W'(CNT_W - 1);
                        state_reg <= S_MUL_C;
                    end
                end
                S_SATCHK:
                begin
                    if (ge)
                    begin
                        r2q_reg   <= R2_SAT_Q;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        r2q_reg   <= '0;
                        mm_reg    <= mm_reg >> 1;
                        step_reg  <= STEP_W'(R2_W - 1);
                        state_reg <= S_R2Q;
                    end
                end
                S_R2Q:
                begin
                    if (ge)
                    begin
                        acc_reg <= alu_res;
                    end
                    r2q_reg  <= {r2q_reg[R2_W-2:0], ge};
                    mm_reg   <= mm_reg >> 1;
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        qc        = (r2q_reg >= R2_SAT_Q) ? R2_SAT_Q : r2q_reg;
        res.mae   = mae_reg;
        res.mse   = mse_reg;
        res.rmse  = sr_reg[RMSE_W-1:0];
        res.r2    = undef_reg ? '0 : (R2_ONE - qc);
        res.undef = undef_reg;
        res.cnt   = cnt_reg;
        res.ovf   = ovf_reg;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE) && out_free;

endmodule

`default_nettype wire

// ===== src/regression_error_metrics_unit.sv =====
// A pair marked last holds pair_stall through the sequenced work (two
// divisions, root, two or three products, the R2 quotient unless R2 is
// undefined or saturates) in one shared add/subtract unit, longer while the
// output register still holds an untaken result. Result valid rises after the work.
// Throughput: one pair per cycle between results. The result register frees
// the sequencer once loaded. Reset clears accumulators, sequencer and valid.
`default_nettype none

module regression_error_metrics_unit
    import rem_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pair_valid,
    output logic                     pair_stall,
    input  logic signed [SAMPLE_W-1:0] prediction,
    input  logic signed [SAMPLE_W-1:0] label,
    input  logic                     last,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [MAE_W-1:0]         mean_abs_error,
    output logic [MSE_W-1:0]         mean_sq_error,
    output logic [RMSE_W-1:0]        root_mean_sq_error,
    output logic signed [R2_W-1:0]   r2_score,
    output logic                     r2_undefined,
    output logic [CNT_W-1:0]         item_count,
    output logic                     count_overflow
);

    logic  take, busy, done, out_free, valid_reg;
    snap_t snap;
    res_t  res, res_reg;

    assign take     = pair_valid && !busy;
    assign out_free = !valid_reg || !result_stall;

    rem_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .last       (last),
        .prediction (prediction),
        .label      (label),
        .snap       (snap)
    );

    rem_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (take && last),
        .snap     (snap),
        .out_free (out_free),
        .busy     (busy),
        .done     (done),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (done)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            res_reg <= res;
        end
    end

    assign pair_stall         = busy;
    assign result_valid       = valid_reg;
    assign mean_abs_error     = res_reg.mae;
    assign mean_sq_error      = res_reg.mse;
    assign root_mean_sq_error = res_reg.rmse;
    assign r2_score           = res_reg.r2;
    assign r2_undefined       = res_reg.undef;
    assign item_count         = res_reg.cnt;
    assign count_overflow     = res_reg.ovf;

endmodule

`default_nettype wire

// ===== src/rem_checker.sv =====
// Port-level checker for the regression error metrics unit, bound to the top.
// Depends on rem_pkg and the assertion macro header.
`default_nettype none
`include "regression_error_metrics_unit_macros.svh"

module rem_checker
    import rem_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       pair_valid,
    input wire logic                       pair_stall,
    input wire logic                       last,
    input wire logic                       result_valid,
    input wire logic                       result_stall,
    input wire logic signed [R2_W-1:0]     r2_score,
    input wire logic                       r2_undefined,
    input wire logic [CNT_W-1:0]           item_count
);

    `REM_ASSERT_NEXT(a_result_holds, result_valid && result_stall, result_valid)
    `REM_ASSERT_NEXT(a_last_stalls, pair_valid && !pair_stall && last, pair_stall)
    `REM_ASSERT_SAME(a_undef_zero, result_valid && r2_undefined, r2_score == '0)
    `REM_ASSERT_SAME(a_count_nonzero, result_valid, item_count != '0)

endmodule

bind regression_error_metrics_unit rem_checker u_rem_checker (.*);

`default_nettype wire
